### sv/ort_pkg.sv
package ort_pkg;

    localparam int COORD_W = 8;
    localparam int DIST_W  = 18;
    localparam int ERR_W   = 10;

    localparam logic [2:0] CMD_MARK_HIT  = 3'd0;
    localparam logic [2:0] CMD_MARK_FREE = 3'd1;
    localparam logic [2:0] CMD_CAST_RAY  = 3'd2;
    localparam logic [2:0] CMD_READ_CELL = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_FREE    = 2'd1;
    localparam logic [1:0] CLS_OCC     = 2'd2;

    localparam logic CFG_DMIN = 1'b0;
    localparam logic CFG_DMAX = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_WR,
        S_LOAD,
        S_STEP,
        S_RD,
        S_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

endpackage

### sv/ort_mem.sv
module ort_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [2:0]        i_wdata,
    output logic [2:0]        o_rdata
);

    // bit 2: hit flag, bits 1:0: cell class
    logic [2:0] r_mem [DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ort_walker.sv
module ort_walker (
    input  logic                       i_clk,
    input  ort_pkg::t_walk_ctl         i_ctl,
    input  logic [ort_pkg::COORD_W-1:0] i_sx,
    input  logic [ort_pkg::COORD_W-1:0] i_sy,
    input  logic [ort_pkg::COORD_W-1:0] i_ex,
    input  logic [ort_pkg::COORD_W-1:0] i_ey,
    output logic [ort_pkg::COORD_W-1:0] o_x,
    output logic [ort_pkg::COORD_W-1:0] o_y,
    output logic [ort_pkg::DIST_W-1:0]  o_dist,
    output logic                       o_done
);
    import ort_pkg::*;

    logic signed [COORD_W:0]  dx, dy;
    logic [COORD_W-1:0]       ax, ay;
    logic signed [1:0]        ix, iy;
    logic signed [ERR_W-1:0]  err_sub;
    logic signed [COORD_W:0]  rel_x, rel_y;
    logic [COORD_W-1:0]       mag_x, mag_y;
    logic [2*COORD_W-1:0]     sq_x, sq_y;

    logic [COORD_W-1:0]       r_x, r_y, r_sx, r_sy;
    logic [COORD_W-1:0]       r_slow, r_fast, r_j;
    logic signed [1:0]        r_ddx, r_ddy, r_pdx, r_pdy;
    logic signed [ERR_W-1:0]  r_err;
    logic [DIST_W-1:0]        r_dist;

    always_comb begin
        dx = $signed({1'b0, i_ex}) - $signed({1'b0, i_sx});
        dy = $signed({1'b0, i_ey}) - $signed({1'b0, i_sy});
        ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        ix = dx[COORD_W] ? -2'sd1 : ((dx != 0) ? 2'sd1 : 2'sd0);
        iy = dy[COORD_W] ? -2'sd1 : ((dy != 0) ? 2'sd1 : 2'sd0);
        err_sub = r_err - $signed({2'b00, r_slow});
        rel_x = $signed({1'b0, r_x}) - $signed({1'b0, r_sx});
        rel_y = $signed({1'b0, r_y}) - $signed({1'b0, r_sy});
        mag_x = rel_x[COORD_W] ? COORD_W'(-rel_x) : rel_x[COORD_W-1:0];
        mag_y = rel_y[COORD_W] ? COORD_W'(-rel_y) : rel_y[COORD_W-1:0];
        sq_x  = mag_x * mag_x;
        sq_y  = mag_y * mag_y;
    end

    always_ff @(posedge i_clk) begin
        // sum of squared offsets from the start, registered from the current position
        r_dist <= DIST_W'(sq_x) + DIST_W'(sq_y);
        if (i_ctl.load) begin
            r_x   <= i_sx;
            r_y   <= i_sy;
            r_sx  <= i_sx;
            r_sy  <= i_sy;
            r_ddx <= ix;
            r_ddy <= iy;
            r_j   <= '0;
            if (ax > ay) begin
                r_pdx  <= ix;
                r_pdy  <= 2'sd0;
                r_slow <= ay;
                r_fast <= ax;
                r_err  <= $signed({2'b00, ax >> 1});
            end else begin
                r_pdx  <= 2'sd0;
                r_pdy  <= iy;
                r_slow <= ax;
                r_fast <= ay;
                r_err  <= $signed({2'b00, ay >> 1});
            end
        end else if (i_ctl.step) begin
            r_j <= r_j + 1'b1;
            if (err_sub < 0) begin
                r_err <= err_sub + $signed({2'b00, r_fast});
                r_x   <= r_x + COORD_W'(r_ddx);
                r_y   <= r_y + COORD_W'(r_ddy);
            end else begin
                r_err <= err_sub;
                r_x   <= r_x + COORD_W'(r_pdx);
                r_y   <= r_y + COORD_W'(r_pdy);
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_dist = r_dist;
    assign o_done = (r_j == r_fast);

endmodule

### sv/occupancy_ray_trace_top.sv
// channel | direction | handshake                 | payload
// cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// in      | in        | i_in_valid / o_in_ready   | i_cmd, i_cell_x/y, i_end_x/y
// out     | out       | o_out_valid / i_out_ready | o_cell_class, o_obstacle_*
// Mark commands read, modify and write back one cell, a read command only reads it; unused codes go to the result.
// A ray cast walks the ray cell by cell through the single-port cell memory, and after a hit
// walks it a second time to mark the cells before the hit free, so it makes up to two walks.
// Reset and the clear command both sweep all GRID_W * GRID_H cells of the memory;
// no input is taken meanwhile.
// A result waits in the output register; a stalled output holds the next result.
module occupancy_ray_trace_top #(
    parameter int GRID_W = 256,
    parameter int GRID_H = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [ort_pkg::DIST_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_cmd,
    input  logic [ort_pkg::COORD_W-1:0] i_cell_x,
    input  logic [ort_pkg::COORD_W-1:0] i_cell_y,
    input  logic [ort_pkg::COORD_W-1:0] i_end_x,
    input  logic [ort_pkg::COORD_W-1:0] i_end_y,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_cell_class,
    output logic                        o_obstacle_found,
    output logic [ort_pkg::COORD_W-1:0] o_obstacle_x,
    output logic [ort_pkg::COORD_W-1:0] o_obstacle_y
);
    import ort_pkg::*;

    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state r_state, n_state;
    t_walk_ctl walk_ctl;

    logic [DIST_W-1:0]  r_dmin, r_dmax;
    logic [2:0]         r_cmd;
    logic [COORD_W-1:0] r_cx, r_cy, r_ex, r_ey;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_clr_res, r_pass2;
    logic [1:0]         r_cls;
    logic               r_found;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic               r_out_valid;
    logic [1:0]         r_o_cls;
    logic               r_o_found;
    logic [COORD_W-1:0] r_o_x, r_o_y;

    logic [COORD_W-1:0] wx, wy;
    logic [DIST_W-1:0]  wdist;
    logic               wdone;

    logic               mem_en, mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [2:0]         mem_wdata, mem_rdata;
    logic               in_xfer, cell_ok, walk_ok, obstacle, clr_last, out_free;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        logic [ADDR_W+COORD_W-1:0] a;
        a = (ADDR_W+COORD_W)'(y) * (ADDR_W+COORD_W)'(GRID_W) + (ADDR_W+COORD_W)'(x);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y);
        return (int'(x) < GRID_W) && (int'(y) < GRID_H);
    endfunction

    ort_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ort_walker u_walker (
        .i_clk  (i_clk),
        .i_ctl  (walk_ctl),
        .i_sx   (r_cx),
        .i_sy   (r_cy),
        .i_ex   (r_ex),
        .i_ey   (r_ey),
        .o_x    (wx),
        .o_y    (wy),
        .o_dist (wdist),
        .o_done (wdone)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign cell_ok     = in_grid(r_cx, r_cy);
    assign walk_ok     = in_grid(wx, wy);
    assign obstacle    = walk_ok && mem_rdata[2] && (wdist < r_dmax) && (wdist >= r_dmin);
    assign clr_last    = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        walk_ctl  = '0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = cell_addr(r_cx, r_cy);
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (clr_last) begin
                    n_state = r_clr_res ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_cmd)
                        CMD_MARK_HIT, CMD_MARK_FREE, CMD_READ_CELL: n_state = S_CELL_RD;
                        CMD_CAST_RAY: n_state = S_LOAD;
                        CMD_CLEAR:    n_state = S_CLEAR;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_CELL_RD: begin
                mem_en  = 1'b1;
                n_state = S_CELL_WR;
            end
            S_CELL_WR: begin
                mem_en = cell_ok && (r_cmd != CMD_READ_CELL);
                mem_we = 1'b1;
                mem_wdata = (r_cmd == CMD_MARK_HIT) ? {1'b1, mem_rdata[1:0]}
                                                    : {mem_rdata[2], CLS_FREE};
                n_state = S_DONE;
            end
            S_LOAD: begin
                walk_ctl.load = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (wdone) begin
                    n_state = S_DONE;
                end else begin
                    walk_ctl.step = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mem_en   = 1'b1;
                mem_addr = cell_addr(wx, wy);
                n_state  = S_CHK;
            end
            S_CHK: begin
                mem_addr = cell_addr(wx, wy);
                mem_we   = 1'b1;
                n_state  = S_STEP;
                if (!r_pass2) begin
                    mem_wdata = {mem_rdata[2], CLS_OCC};
                    if (obstacle) begin
                        mem_en = 1'b1;
                        walk_ctl.load = 1'b1;
                    end
                end else begin
                    mem_wdata = {mem_rdata[2], CLS_FREE};
                    if (walk_ok && mem_rdata[1:0] == CLS_OCC) begin
                        n_state = S_DONE;
                    end else if (walk_ok && mem_rdata[1:0] == CLS_UNKNOWN
                                 && wdist < r_dmax) begin
                        mem_en = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_res   <= 1'b0;
            r_out_valid <= 1'b0;
            r_dmin      <= DIST_W'(100);
            r_dmax      <= DIST_W'(10000);
            r_pass2     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DMIN) begin
                    r_dmin <= i_cfg_data;
                end else begin
                    r_dmax <= i_cfg_data;
                end
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (in_xfer) begin
                r_clr_res <= (i_cmd == CMD_CLEAR);
                r_pass2   <= 1'b0;
            end
            if (r_state == S_CHK && !r_pass2 && obstacle) begin
                r_pass2 <= 1'b1;
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_cmd;
            r_cx    <= i_cell_x;
            r_cy    <= i_cell_y;
            r_ex    <= i_end_x;
            r_ey    <= i_end_y;
            r_cls   <= CLS_UNKNOWN;
            r_found <= 1'b0;
            r_ox    <= '0;
            r_oy    <= '0;
        end
        if (r_state == S_CELL_WR && r_cmd == CMD_READ_CELL && cell_ok) begin
            r_cls <= mem_rdata[1:0];
        end
        if (r_state == S_CHK && !r_pass2 && obstacle) begin
            r_found <= 1'b1;
            r_ox    <= wx;
            r_oy    <= wy;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_cls   <= r_cls;
            r_o_found <= r_found;
            r_o_x     <= r_ox;
            r_o_y     <= r_oy;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_class     = r_o_cls;
    assign o_obstacle_found = r_o_found;
    assign o_obstacle_x     = r_o_x;
    assign o_obstacle_y     = r_o_y;

endmodule

### sv/ort_checker.sv
module ort_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_cell_class,
    input logic       o_obstacle_found,
    input logic [7:0] o_obstacle_x,
    input logic [7:0] o_obstacle_y
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_obstacle_x)
        && $stable(o_obstacle_y) && $stable(o_cell_class))
        else $error("stalled result changed");

    a_no_obstacle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_obstacle_found |-> o_obstacle_x == 8'd0 && o_obstacle_y == 8'd0)
        else $error("obstacle position without obstacle");

    a_obstacle_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_obstacle_found |-> o_cell_class == 2'd0)
        else $error("ray result carries a class");

    a_clear_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("input taken during reset sweep");

endmodule

bind occupancy_ray_trace_top ort_checker u_ort_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_cell_class     (o_cell_class),
    .o_obstacle_found (o_obstacle_found),
    .o_obstacle_x     (o_obstacle_x),
    .o_obstacle_y     (o_obstacle_y)
);

### tb/sv/tb_occupancy_ray_trace_top.sv
`timescale 1ns / 100ps

module tb_occupancy_ray_trace_top;
    import ort_pkg::*;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] cx, cy, ex, ey;
    } t_grid_cmd;

    typedef struct {
        logic [1:0] cls;
        logic       found;
        logic [7:0] ox, oy;
    } t_grid_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [DIST_W-1:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd = '0;
    logic [7:0]  i_cell_x = '0, i_cell_y = '0, i_end_x = '0, i_end_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_cell_class;
    logic        o_obstacle_found;
    logic [7:0]  o_obstacle_x, o_obstacle_y;

    occupancy_ray_trace_top dut (.*);

    always #5 i_clk = ~i_clk;

    bit           hit_map [65536];
    logic [1:0]   class_map [65536];
    int           dmin_sq, dmax_sq;

    t_grid_cmd    cmd_q[$];
    t_grid_answer answer_q[$];
    int           send_idle, recv_idle;
    int           errors;
    bit           cmd_taken;

    function automatic void clear_grid();
        foreach (hit_map[i]) begin
            hit_map[i] = 1'b0;
            class_map[i] = CLS_UNKNOWN;
        end
    endfunction

    // k-th cell of the Bresenham walk from (sx,sy) to (ex,ey), k from 1
    function automatic void ray_cell(int sx, int sy, int ex, int ey, int k,
                                     output int x, output int y);
        int dx, dy, ax, ay, ix, iy, slow, fast, err, pdx, pdy;
        dx = ex - sx; dy = ey - sy;
        ix = (dx > 0) - (dx < 0); iy = (dy > 0) - (dy < 0);
        ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy;
        if (ax > ay) begin
            pdx = ix; pdy = 0; slow = ay; fast = ax;
        end else begin
            pdx = 0; pdy = iy; slow = ax; fast = ay;
        end
        x = sx; y = sy; err = fast / 2;
        for (int j = 0; j < k; j++) begin
            err -= slow;
            if (err < 0) begin
                err += fast; x += ix; y += iy;
            end else begin
                x += pdx; y += pdy;
            end
        end
    endfunction

    function automatic int ray_len(int sx, int sy, int ex, int ey);
        int ax, ay;
        ax = ex > sx ? ex - sx : sx - ex;
        ay = ey > sy ? ey - sy : sy - ey;
        return ax > ay ? ax : ay;
    endfunction

    function automatic t_grid_answer predict_grid(t_grid_cmd c);
        t_grid_answer r;
        int fast, x, y, a, b, d;
        logic [15:0] adr;
        r = '{default: '0};
        adr = {c.cy, c.cx};
        case (c.cmd)
            CMD_MARK_HIT:  hit_map[adr] = 1'b1;
            CMD_MARK_FREE: class_map[adr] = CLS_FREE;
            CMD_READ_CELL: r.cls = class_map[adr];
            CMD_CLEAR:     clear_grid();
            CMD_CAST_RAY: begin
                fast = ray_len(c.cx, c.cy, c.ex, c.ey);
                for (int j = 1; j <= fast; j++) begin
                    ray_cell(c.cx, c.cy, c.ex, c.ey, j, x, y);
                    a = x - c.cx; b = y - c.cy; d = a * a + b * b;
                    if (hit_map[y * 256 + x] && d < dmax_sq && d >= dmin_sq) begin
                        class_map[y * 256 + x] = CLS_OCC;
                        r.found = 1'b1; r.ox = 8'(x); r.oy = 8'(y);
                        break;
                    end
                end
                if (r.found) begin
                    for (int j = 1; j <= fast; j++) begin
                        ray_cell(c.cx, c.cy, c.ex, c.ey, j, x, y);
                        a = x - c.cx; b = y - c.cy; d = a * a + b * b;
                        if (class_map[y * 256 + x] == CLS_OCC) break;
                        if (class_map[y * 256 + x] == CLS_UNKNOWN && d < dmax_sq)
                            class_map[y * 256 + x] = CLS_FREE;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // input side: capture transfers at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        t_grid_cmd c_in;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            c_in = '{i_cmd, i_cell_x, i_cell_y, i_end_x, i_end_y};
            answer_q.insert(answer_q.size(), predict_grid(c_in));
            cmd_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_grid_cmd c;
        logic      nxt_valid;
        nxt_valid = i_in_valid;
        if (!i_in_valid || cmd_taken) begin
            nxt_valid = 1'b0;
            if (i_rst_n && cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                c = cmd_q.pop_front();
                i_cmd <= c.cmd; i_cell_x <= c.cx; i_cell_y <= c.cy;
                i_end_x <= c.ex; i_end_y <= c.ey;
                nxt_valid = 1'b1;
            end
        end
        cmd_taken = 1'b0;
        i_in_valid <= nxt_valid;
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_grid_answer e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answer_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = answer_q.pop_front();
                if (e.cls !== o_cell_class || e.found !== o_obstacle_found ||
                    e.ox !== o_obstacle_x || e.oy !== o_obstacle_y) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t: exp cls %0d found %0d (%0d,%0d) got cls %0d found %0d (%0d,%0d)",
                            $realtime, e.cls, e.found, e.ox, e.oy, o_cell_class,
                            o_obstacle_found, o_obstacle_x, o_obstacle_y);
                end
            end
        end
    end

    task automatic write_reg(logic idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= DIST_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DMIN) dmin_sq = val; else dmax_sq = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(logic [2:0] c, int cx, int cy, int ex = 0, int ey = 0);
        t_grid_cmd item;
        item = '{c, cx[7:0], cy[7:0], ex[7:0], ey[7:0]};
        cmd_q.insert(cmd_q.size(), item);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (cmd_q.size() > 0 || i_in_valid || answer_q.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int clamp(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    task automatic random_items(int n, ref int clears_left);
        int sx, sy, ex, ey, len, x, y, cnt;
        cnt = 0;
        while (cnt < n) begin
            sx = $urandom_range(255); sy = $urandom_range(255);
            if ($urandom_range(19) == 0) begin
                ex = $urandom_range(255); ey = $urandom_range(255);
            end else begin
                ex = clamp(sx + $urandom_range(40) - 20);
                ey = clamp(sy + $urandom_range(40) - 20);
            end
            len = ray_len(sx, sy, ex, ey);
            case ($urandom_range(9))
                0: begin
                    push_cmd(3'($urandom_range(7)), $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
                    cnt++;
                end
                1: begin
                    if (clears_left > 0 && $urandom_range(9) == 0) begin
                        push_cmd(CMD_CLEAR, sx, sy, ex, ey);
                        clears_left--;
                        cnt++;
                    end else begin
                        push_cmd(3'(5 + $urandom_range(2)), sx, sy, ex, ey);
                        cnt++;
                    end
                end
                default: begin
                    // seed hits on the path, cast, then look at the result
                    repeat ($urandom_range(3)) begin
                        if (len > 0) begin
                            ray_cell(sx, sy, ex, ey, $urandom_range(len, 1), x, y);
                            push_cmd(CMD_MARK_HIT, x, y);
                            cnt++;
                        end
                    end
                    if ($urandom_range(5) == 0 && len > 0) begin
                        ray_cell(sx, sy, ex, ey, $urandom_range(len, 1), x, y);
                        push_cmd(CMD_MARK_FREE, x, y);
                        cnt++;
                    end
                    push_cmd(CMD_CAST_RAY, sx, sy, ex, ey);
                    cnt++;
                    repeat ($urandom_range(3)) begin
                        if (len > 0) ray_cell(sx, sy, ex, ey, $urandom_range(len, 1), x, y);
                        else begin x = sx; y = sy; end
                        push_cmd(CMD_READ_CELL, x, y, $urandom_range(255), $urandom_range(255));
                        cnt++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        int clears_left;
        dmin_sq = 100; dmax_sq = 10000;
        errors = 0; cmd_taken = 1'b0; clears_left = 3;
        send_idle = 37; recv_idle = 77;
        clear_grid();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_DMIN, 100);
        write_reg(CFG_DMAX, 10000);
        // hit too close is skipped, next one inside the window becomes occupied
        push_cmd(CMD_MARK_HIT, 5, 5);
        push_cmd(CMD_MARK_HIT, 20, 20);
        push_cmd(CMD_CAST_RAY, 0, 0, 255, 255);
        push_cmd(CMD_READ_CELL, 20, 20);
        push_cmd(CMD_READ_CELL, 5, 5);
        push_cmd(CMD_READ_CELL, 21, 21);
        push_cmd(CMD_CAST_RAY, 40, 40, 40, 40);
        push_cmd(CMD_MARK_HIT, 255, 255);
        push_cmd(CMD_CAST_RAY, 255, 0, 255, 255);
        push_cmd(CMD_MARK_HIT, 250, 3);
        push_cmd(CMD_CAST_RAY, 255, 0, 0, 5);
        push_cmd(CMD_READ_CELL, 252, 2);
        push_cmd(CMD_MARK_FREE, 20, 20);
        push_cmd(CMD_READ_CELL, 20, 20);
        push_cmd(3'd5, 255, 255, 255, 255);
        push_cmd(3'd6, 0, 0, 0, 0);
        push_cmd(3'd7, 170, 85, 85, 170);
        push_cmd(CMD_CLEAR, 0, 0);
        push_cmd(CMD_READ_CELL, 250, 3);
        push_cmd(CMD_CAST_RAY, 255, 0, 0, 5);
        random_items(380, clears_left);
        drain();

        send_idle = 77; recv_idle = 37;
        write_reg(CFG_DMIN, 0);
        write_reg(CFG_DMAX, 131072);
        push_cmd(CMD_MARK_HIT, 0, 255);
        push_cmd(CMD_CAST_RAY, 0, 0, 0, 255);
        random_items(400, clears_left);
        drain();

        send_idle = 0; recv_idle = 0;
        write_reg(CFG_DMIN, 2);
        write_reg(CFG_DMAX, 300);
        random_items(300, clears_left);
        drain();

        write_reg(CFG_DMIN, 131072);
        write_reg(CFG_DMAX, 0);
        random_items(70, clears_left);
        drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb_occupancy_ray_trace_top: done, clean");
        else
            $display("tb_occupancy_ray_trace_top: done, errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_occupancy_ray_trace_top: done, errors");
        $finish;
    end

endmodule
